// ===== rtl/core/token_bucket_packet_shaper_macros.svh =====
// Assertion macros used by the token bucket shaper back end.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define TBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that one condition implies another on the following clock edge.
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tbs_pkg.sv =====
// Types, constants and event codes of the token bucket shaper.
package tbs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned PAddrW     = 3;
  localparam logic [15:0] DepthReset = 16'd10;

  typedef enum logic [2:0] {
    EvQueued   = 3'd0,
    EvDropBig  = 3'd1,
    EvDropFull = 3'd2,
    EvTokAdd   = 3'd3,
    EvTokDrop  = 3'd4,
    EvReleased = 3'd5
  } event_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] packet_id;
    logic [15:0] tokens_needed;
  } req_t;

  typedef struct packed {
    event_e      event_code;
    logic [15:0] event_packet_id;
    logic [15:0] bucket_level;
    logic [4:0]  queue_count;
    logic        last_result;
  } res_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic        is_tick;
    logic        oversize;
    logic [15:0] id;
    logic [15:0] need;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] need;
  } wq_entry_t;

endpackage

// ===== rtl/core/tbs_front.sv =====
// Front end: accept requests, classify them, hand them to the command queue.
module tbs_front
  import tbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] bucket_depth_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic f_valid_q, f_valid_d;
  cmd_t f_cmd_q;
  logic accept;

  assign in_ready_o  = !f_valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = f_valid_q;
  assign cmd_o       = f_cmd_q;

  // Hold a request until the queue takes it.
  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // Classify on entry: tick or arrival, and oversize against the depth.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_cmd_q.is_tick  <= in_data_i.req_type;
      f_cmd_q.oversize <= in_data_i.tokens_needed > bucket_depth_i;
      f_cmd_q.id       <= in_data_i.packet_id;
      f_cmd_q.need     <= in_data_i.tokens_needed;
    end
  end

endmodule

// ===== rtl/core/tbs_cmd_fifo.sv =====
// Two-entry command queue between the front and back ends.
module tbs_cmd_fifo
  import tbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and count.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/tbs_back.sv =====
// Back end: bucket state, waiting queue memory, release loop and result register.
module tbs_back
  import tbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] bucket_depth_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o
);

`include "token_bucket_packet_shaper_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  logic [1:0]      state_q, state_d;
  logic [15:0]     level_q, level_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] rel_q, rel_d;
  res_t            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;

  wq_entry_t mem_q [QueueDepth];
  wq_entry_t rd_q;
  logic      mem_we;
  logic      slot_free;
  logic      push, push_last;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequence one command: classify outcome, then release queue heads on a tick.
  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    rel_d       = rel_q;
    pend_d      = pend_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    push        = 1'b0;
    push_last   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          pend_d.event_packet_id = cmd_i.id;
          pend_d.last_result     = 1'b0;
          if (!cmd_i.is_tick) begin
            state_d = S_FINAL;
            if (cmd_i.oversize) begin
              pend_d.event_code = EvDropBig;
            end else if (fill_q == CntFull) begin
              pend_d.event_code = EvDropFull;
            end else begin
              mem_we            = 1'b1;
              tail_d            = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
              fill_d            = fill_q + 1'b1;
              pend_d.event_code = EvQueued;
            end
          end else begin
            rel_d                  = '0;
            pend_d.event_packet_id = '0;
            if (level_q < bucket_depth_i) begin
              level_d           = level_q + 16'd1;
              pend_d.event_code = EvTokAdd;
            end else begin
              pend_d.event_code = EvTokDrop;
            end
            state_d = (fill_q == '0) ? S_FINAL : S_CHECK;
          end
          pend_d.bucket_level = level_d;
          pend_d.queue_count  = 5'(fill_d);
        end
      end
      S_CHECK: begin
        if (rel_q != CntFull && fill_q != '0 && level_q >= rd_q.need) begin
          // Release the head once the previous result can go out.
          if (slot_free) begin
            push                   = 1'b1;
            level_d                = level_q - rd_q.need;
            head_d                 = (head_q == PtrLast) ? '0 : head_q + 1'b1;
            fill_d                 = fill_q - 1'b1;
            rel_d                  = rel_q + 1'b1;
            pend_d.event_code      = EvReleased;
            pend_d.event_packet_id = rd_q.id;
            pend_d.bucket_level    = level_d;
            pend_d.queue_count     = 5'(fill_d);
            pend_d.last_result     = 1'b0;
            state_d                = S_WAIT;
          end
        end else begin
          state_d = S_FINAL;
        end
      end
      S_WAIT: begin
        // Let the memory read of the new head settle.
        state_d = S_CHECK;
      end
      S_FINAL: begin
        if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load the result register, or drain it when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d       = 1'b1;
      out_d             = pend_q;
      out_d.last_result = push_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      rel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Waiting queue: write at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= '{id: cmd_i.id, need: cmd_i.need};
    end
    rd_q <= mem_q[head_q];
  end

  `TBS_ASSERT(a_fill_bound, fill_q <= CntFull, "queue fill exceeds depth")
  `TBS_ASSERT(a_ring_consistent, (tail_q - head_q) == fill_q[PtrW-1:0],
  "ring pointers disagree with fill")
  `TBS_ASSERT_NEXT(a_wait_then_check, state_q == S_WAIT, state_q == S_CHECK,
  "release loop skipped the head check")

endmodule

// ===== rtl/core/token_bucket_packet_shaper.sv =====
// An arrival gives one result; a tick gives one token result and then one result per released
// packet, the last of them marked last_result. The back end takes one command at a time;
// the front register and the two-entry command queue hold further requests meanwhile, and
// each release costs a head check plus a registered read of the waiting queue memory.
// Reset clears bucket level, queue pointers and all handshake state, and sets
// bucket_depth to 10; the waiting queue memory is not cleared.
module token_bucket_packet_shaper
  import tbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] depth_q;
  logic        sel_depth;
  logic        f_valid, f_ready;
  cmd_t        f_cmd;
  logic        b_valid, b_ready;
  cmd_t        b_cmd;

  // Decode the single configuration register at word 0.
  assign pready    = 1'b1;
  assign sel_depth = !paddr[2];
  assign prdata    = sel_depth ? {16'd0, depth_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DepthReset;
    end else if (psel && penable && pwrite && sel_depth) begin
      depth_q <= pwdata[15:0];
    end
  end

  tbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_depth_i (depth_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .cmd_valid_o    (f_valid),
    .cmd_ready_i    (f_ready),
    .cmd_o          (f_cmd)
  );

  tbs_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  tbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_depth_i (depth_q),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_i          (b_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the token bucket packet shaper.
module testbench
  import tbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 30;
  localparam int unsigned DrainCycles = 4 + 2 * QueueDepth + 4;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 1000000;
  localparam logic [PAddrW-1:0] DepthAddr = '0;

  // Predict shaper events and match them against the block's results.
  class event_ledger;
    logic [15:0] depth;
    logic [15:0] level;
    wq_entry_t   waiting[$];
    res_t        pending_events[$];
    int          mismatches;
    int          checked;

    function new();
      depth      = DepthReset;
      level      = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_depth(logic [15:0] d);
      depth = d;
    endfunction

    function int pending_count();
      return pending_events.size();
    endfunction

    function void add_event(event_e code, logic [15:0] id);
      res_t ev;
      ev.event_code      = code;
      ev.event_packet_id = id;
      ev.bucket_level    = level;
      ev.queue_count     = 5'(waiting.size());
      ev.last_result     = 1'b0;
      pending_events.push_back(ev);
    endfunction

    // Work out every event caused by one accepted request.
    function void note_request(req_t r);
      wq_entry_t   head;
      int unsigned n_rel;
      res_t        tail_ev;
      if (!r.req_type) begin
        // Oversize wins over a full queue.
        if (r.tokens_needed > depth) begin
          add_event(EvDropBig, r.packet_id);
        end else if (waiting.size() >= QueueDepth) begin
          add_event(EvDropFull, r.packet_id);
        end else begin
          head.id   = r.packet_id;
          head.need = r.tokens_needed;
          waiting.push_back(head);
          add_event(EvQueued, r.packet_id);
        end
      end else begin
        if (level < depth) begin
          level = level + 16'd1;
          add_event(EvTokAdd, 16'h0);
        end else begin
          add_event(EvTokDrop, 16'h0);
        end
        // Release heads in order while the bucket covers them.
        n_rel = 0;
        while (waiting.size() > 0 && n_rel < QueueDepth && level >= waiting[0].need) begin
          head  = waiting.pop_front();
          level = level - head.need;
          n_rel++;
          add_event(EvReleased, head.id);
        end
      end
      tail_ev = pending_events.pop_back();
      tail_ev.last_result = 1'b1;
      pending_events.push_back(tail_ev);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH %s", msg);
    endtask

    // Compare one result with the oldest predicted event.
    task check_event(res_t got);
      res_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("result with nothing predicted: %h", got));
        return;
      end
      want = pending_events.pop_front();
      checked++;
      if (got.event_code !== want.event_code ||
          got.event_packet_id !== want.event_packet_id ||
          got.bucket_level !== want.bucket_level ||
          got.queue_count !== want.queue_count ||
          got.last_result !== want.last_result) begin
        report_mismatch($sformatf(
          "event %0d: got code %0d id %h level %0d count %0d last %b, want %0d %h %0d %0d %b",
          checked, got.event_code, got.event_packet_id, got.bucket_level, got.queue_count,
          got.last_result, want.event_code, want.event_packet_id, want.bucket_level,
          want.queue_count, want.last_result));
      end
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  res_t              out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PAddrW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  event_ledger ledger = new();

  int          src_mode   = 1;
  int          sink_mode  = 1;
  bit          hold_req   = 1'b0;
  int          n_ticks    = 0;
  int          n_arrivals = 0;
  int          n_settings = 0;
  int unsigned cycles     = 0;

  int unsigned phase_depth [NumPhases]    = '{3, 65535, 1, 7, 0, 200, 2, 16};
  int unsigned phase_tick_pct [NumPhases] = '{45, 50, 30, 55, 45, 40, 60, 45};

  token_bucket_packet_shaper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_event(out_data_o);
  end

  // Drive the result side: random stalls, or one long hold-off on request.
  initial begin : sink
    int stall;
    int sel;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        if (sink_mode != 0) begin
          sel = $urandom_range(0, 99);
          if (sel < 12) stall = $urandom_range(1, 3);
          else if (sel < 14) stall = $urandom_range(20, 60);
        end
        out_ready_i <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  function automatic int pick_gap();
    int sel;
    if (src_mode == 0) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t tick_request();
    req_t r;
    r.req_type      = 1'b1;
    r.packet_id     = 16'($urandom);
    r.tokens_needed = 16'($urandom);
    return r;
  endfunction

  function automatic req_t arrival_request(logic [15:0] id, logic [15:0] need);
    req_t r;
    r.req_type      = 1'b0;
    r.packet_id     = id;
    r.tokens_needed = need;
    return r;
  endfunction

  // Mostly in-range arrivals and ticks, with some oversize noise.
  function automatic req_t random_request(int unsigned d, int unsigned tick_pct);
    req_t        r;
    int unsigned sel;
    int unsigned lim;
    r.req_type      = 1'b0;
    r.packet_id     = 16'($urandom);
    r.tokens_needed = 16'($urandom);
    lim = (d < 6) ? d : 6;
    sel = $urandom_range(0, 99);
    if (sel < tick_pct) begin
      r.req_type = 1'b1;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 60) r.tokens_needed = 16'($urandom_range(0, lim));
      else if (sel < 75) r.tokens_needed = 16'($urandom_range(0, (d < 255) ? d : 255));
      else if (sel < 85 && d <= 255) r.tokens_needed = 16'(d);
      else if (r.tokens_needed <= d && d > 255) r.tokens_needed = 16'($urandom_range(0, lim));
    end
    return r;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic offer_request(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_request(r);
    if (r.req_type) n_ticks++;
    else n_arrivals++;
  endtask

  // Run one register access: setup cycle, then access until pready.
  task automatic apb_access(bit wr, logic [PAddrW-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the bucket depth and read it back.
  task automatic set_bucket_depth(logic [15:0] d);
    logic [31:0] rd;
    apb_access(1'b1, DepthAddr, {16'h0, d}, rd);
    ledger.set_depth(d);
    apb_access(1'b0, DepthAddr, 32'h0, rd);
    if (rd[15:0] !== d)
      ledger.report_mismatch($sformatf("bucket_depth reads %h after writing %h", rd[15:0], d));
    n_settings++;
  endtask

  // Wait until every predicted event has come out, then let the block settle.
  task automatic wait_drained();
    while (ledger.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : run
    logic [31:0] rd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Check the reset depth.
    apb_access(1'b0, DepthAddr, 32'h0, rd);
    if (rd[15:0] !== DepthReset)
      ledger.report_mismatch($sformatf("bucket_depth reads %h after reset", rd[15:0]));

    // Directed: boundaries, oversize, full queue, zero need, release burst.
    offer_request(tick_request());
    offer_request(arrival_request(16'hFFFF, 16'd1));
    offer_request(arrival_request(16'h0000, 16'd11));
    offer_request(arrival_request(16'hA5A5, 16'hFFFF));
    for (int i = 0; i < 15; i++) offer_request(arrival_request(16'h0100 + 16'(i), 16'd0));
    offer_request(arrival_request(16'h5A5A, 16'd3));
    offer_request(arrival_request(16'h7FFF, 16'd11));
    offer_request(tick_request());
    offer_request(arrival_request(16'h4321, 16'd5));
    in_valid_i <= 1'b0;

    // Lower the depth under the level: ticks drop and the head stays blocked.
    wait_drained();
    set_bucket_depth(16'd0);
    offer_request(tick_request());
    offer_request(arrival_request(16'h8000, 16'd0));
    offer_request(arrival_request(16'h0001, 16'd1));
    offer_request(tick_request());
    in_valid_i <= 1'b0;

    // Random phases, one depth each; one phase runs under a long output hold-off.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      set_bucket_depth(16'(phase_depth[p]));
      src_mode  = (p % 3 != 0);
      sink_mode = src_mode;
      if (p == 2) begin
        src_mode  = 0;
        sink_mode = 1;
        hold_req  = 1'b1;
      end
      for (int k = 0; k < PhaseItems; k++)
        offer_request(random_request(phase_depth[p], phase_tick_pct[p]));
      in_valid_i <= 1'b0;
    end

    wait_drained();
    $display("Covered %0d requests (%0d token ticks, %0d packet arrivals) over %0d depth writes",
             n_ticks + n_arrivals, n_ticks, n_arrivals, n_settings);
    $display("Checked %0d events, %0d still outstanding, %0d errors",
             ledger.checked, ledger.pending_count(), ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
